// ===== src/spnc_pkg.sv =====
package spnc_pkg;

  localparam int ROUND_COUNT = 31;
  localparam int RND_W       = 5;
  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;

  // register indexes of the configuration port
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [BLOCK_W-1:0] state;
    logic [KEY_W-1:0]   key;
  } spnc_stage_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i goes to 16*(i mod 4) + i/4
  function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[16 * (i % 4) + (i / 4)] = s[i];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  // rotate left by 61, top nibble through the S-box, round number into bits 19..15
  function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
                                                input logic [RND_W-1:0] rnd);
    logic [KEY_W-1:0] r;
    r = {k[18:0], k[KEY_W-1:19]};
    r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
    r[19:15] = r[19:15] ^ rnd;
    return r;
  endfunction

endpackage

// ===== src/spnc_round.sv =====
module spnc_round
  import spnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RND_W-1:0]  rnd,
  input  logic              in_valid,
  input  spnc_stage_t       in_stage,
  output logic              out_valid,
  output spnc_stage_t       out_stage
);

  logic        valid_r;
  spnc_stage_t stage_r;
  spnc_stage_t stage_nxt;

  always_comb begin
    stage_nxt.state = perm_layer(sub_layer(in_stage.state ^ round_key(in_stage.key)));
    stage_nxt.key   = next_key(in_stage.key, rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// ===== src/spn_block_cipher_64_80_encrypt.sv =====
// Block encryption engine, 64-bit block, 80-bit key, 31 rounds.
//
// Key: write key_low (index 0, key bits 63..0) and key_high (index 1, key
// bits 79..64, low 16 bits of cfg_data) through cfg_we/cfg_index/cfg_data.
// Write the key only while no word is in flight; both halves reset to 0.
//
// Input: a plaintext word is taken at each clock edge with start high and
// busy low. busy is never raised, so a word can enter on every cycle.
//
// Output: the ciphertext appears on out_ciphertext for one cycle with
// out_valid high. The path from the plaintext runs through the capture
// register, which loads at the edge that took the plaintext, then one
// register per round (31) and one for the final key XOR. Throughput is
// one word per clock. The receiver cannot stall the pipeline, so each
// word leaves exactly once, in order.
//
// Reset (synchronous, rst_n low) clears the key and every valid bit, so
// words in flight are dropped.
module spn_block_cipher_64_80_encrypt
  import spnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [BLOCK_W-1:0] in_plaintext,
  output logic               out_valid,
  output logic [BLOCK_W-1:0] out_ciphertext,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [BLOCK_W-1:0] cfg_data
);

  logic [BLOCK_W-1:0] key_low_r;
  logic [15:0]        key_high_r;

  logic               cap_valid_r;
  spnc_stage_t        cap_stage_r;

  logic               vld   [ROUND_COUNT+1];
  spnc_stage_t        stage [ROUND_COUNT+1];

  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_ciphertext_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // capture the word together with the key it is encrypted under
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_valid_r <= 1'b0;
    end else begin
      cap_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cap_stage_r.state <= in_plaintext;
    cap_stage_r.key   <= {key_high_r, key_low_r};
  end

  assign vld[0]   = cap_valid_r;
  assign stage[0] = cap_stage_r;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    spnc_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .rnd       (RND_W'(g + 1)),
      .in_valid  (vld[g]),
      .in_stage  (stage[g]),
      .out_valid (vld[g+1]),
      .out_stage (stage[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[ROUND_COUNT];
    end
  end

  // final whitening with the last round key
  always_ff @(posedge clk) begin
    out_ciphertext_r <= stage[ROUND_COUNT].state ^ round_key(stage[ROUND_COUNT].key);
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_ciphertext_r;

endmodule
